### design/ccvm_pkg.sv
package ccvm_pkg;

  localparam int DEF_VOICES       = 16;
  localparam int DEF_CLIPS        = 64;
  localparam int DEF_SAMPLE_WORDS = 65536;

  localparam logic signed [16:0] SAT_HI = 17'sd32767;
  localparam logic signed [16:0] SAT_LO = -17'sd32768;

  typedef enum logic [1:0] {
    FN_SAMPLE = 2'd0,
    FN_CLIP   = 2'd1,
    FN_START  = 2'd2,
    FN_TICK   = 2'd3
  } func_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    logic sample_wr;
    logic clip_wr;
    logic voice_start;
    logic clr_mix;
    logic vrd;
    logic crd_v;
    logic follow;
    logic end_v;
    logic srd;
    logic add;
    logic cstart;
    logic crd_last;
    logic cmove;
    logic cdrop;
    logic jinc;
    logic ld_tick;
    logic ld_start;
  } ccvm_cmd_t;

  typedef struct packed {
    logic i_lt_cnt;
    logic pos_ge_len;
    logic has_next;
    logic reloaded;
    logic j_lt_cnt;
    logic ended_j;
    logic last_eq_j;
    logic out_free;
  } ccvm_sts_t;

endpackage

### design/ccvm_ram.sv
module ccvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/ccvm_ctrl.sv
module ccvm_ctrl
  import ccvm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_func,
  output logic      in_stall,
  input  ccvm_sts_t sts,
  output ccvm_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUT_START,
    ST_VOICE,
    ST_CLIP,
    ST_CHK,
    ST_ADD,
    ST_CMP,
    ST_MOVE,
    ST_PUT_TICK
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(in_func))
            FN_SAMPLE: cmd.sample_wr = 1'b1;
            FN_CLIP:   cmd.clip_wr = 1'b1;
            FN_START: begin
              cmd.voice_start = 1'b1;
              state_nxt       = ST_PUT_START;
            end
            FN_TICK: begin
              cmd.clr_mix = 1'b1;
              state_nxt   = ST_VOICE;
            end
            default: ;
          endcase
        end
      end
      ST_PUT_START: begin
        if (sts.out_free) begin
          cmd.ld_start = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_VOICE: begin
        if (sts.i_lt_cnt) begin
          cmd.vrd   = 1'b1;
          state_nxt = ST_CLIP;
        end else begin
          cmd.cstart = 1'b1;
          state_nxt  = ST_CMP;
        end
      end
      ST_CLIP: begin
        cmd.crd_v = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.pos_ge_len) begin
          if (sts.reloaded || !sts.has_next) begin
            cmd.end_v = 1'b1;
            state_nxt = ST_VOICE;
          end else begin
            cmd.follow = 1'b1;
          end
        end else begin
          cmd.srd   = 1'b1;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_VOICE;
      end
      ST_CMP: begin
        if (!sts.j_lt_cnt) begin
          state_nxt = ST_PUT_TICK;
        end else if (!sts.ended_j) begin
          cmd.jinc = 1'b1;
        end else if (sts.last_eq_j) begin
          cmd.cdrop = 1'b1;
        end else begin
          cmd.crd_last = 1'b1;
          state_nxt    = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd.cmove = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_PUT_TICK: begin
        if (sts.out_free) begin
          cmd.ld_tick = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/ccvm_dp.sv
module ccvm_dp
  import ccvm_pkg::*;
#(
  parameter int VOICES       = DEF_VOICES,
  parameter int CLIPS        = DEF_CLIPS,
  parameter int SAMPLE_WORDS = DEF_SAMPLE_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic [15:0]        in_sample_addr,
  input  logic signed [15:0] in_sample_value,
  input  logic [5:0]         in_clip_index,
  input  logic [15:0]        in_clip_start,
  input  logic [16:0]        in_clip_length,
  input  logic               in_has_next,
  input  logic [5:0]         in_next_clip,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [15:0] out_mixed_sample,
  output logic               out_start_accepted,
  output logic [4:0]         out_active_voices,
  input  ccvm_cmd_t          cmd,
  output ccvm_sts_t          sts
);

  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NW  = $clog2(VOICES + 1);
  localparam int CW  = (CLIPS > 1) ? $clog2(CLIPS) : 1;
  localparam int SAW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam int CDW = 16 + 17 + 1 + CW;
  localparam int VDW = CW + 17;

  function automatic logic [64*CW-1:0] build_wrap();
    logic [64*CW-1:0] tab;
    tab = '0;
    for (int k = 0; k < 64; k++) begin
      tab[k*CW +: CW] = CW'(k % CLIPS);
    end
    return tab;
  endfunction

  localparam logic [64*CW-1:0] WRAP_TAB = build_wrap();

  logic              enabled_r;
  logic [NW-1:0]     cnt_r, i_r, j_r;
  logic [NW-1:0]     last;
  logic [VOICES-1:0] ended_r;
  logic signed [15:0] acc_r;
  logic              ok_r;
  logic [CW-1:0]     vclip_r;
  logic [16:0]       vpos_r;
  logic              reloaded_r;

  logic [CDW-1:0]    clip_q;
  logic [VDW-1:0]    voice_q;
  logic [15:0]       sample_q;
  logic [15:0]       c_start;
  logic [16:0]       c_len;
  logic              c_has;
  logic [CW-1:0]     c_next;

  logic              out_valid_r;
  logic              out_kind_r;
  logic signed [15:0] out_mix_r;
  logic              out_ok_r;
  logic [4:0]        out_av_r;

  logic              start_ok;
  logic              v_we;
  logic [VIW-1:0]    v_waddr;
  logic [VDW-1:0]    v_wdata;
  logic [VIW-1:0]    v_raddr;
  logic [CW-1:0]     c_raddr;
  logic [20:0]       s_sum;
  logic signed [16:0] add_s;
  logic signed [15:0] add_sat;

  assign c_start = clip_q[CDW-1 -: 16];
  assign c_len   = clip_q[CW+17 -: 17];
  assign c_has   = clip_q[CW];
  assign c_next  = clip_q[CW-1:0];
  assign last    = cnt_r - NW'(1);

  assign start_ok = enabled_r && (cnt_r < NW'(VOICES));

  always_comb begin
    v_we    = 1'b0;
    v_waddr = i_r[VIW-1:0];
    v_wdata = {vclip_r, vpos_r + 17'd1};
    if (cmd.voice_start) begin
      v_we    = start_ok;
      v_waddr = cnt_r[VIW-1:0];
      v_wdata = {WRAP_TAB[in_clip_index*CW +: CW], 17'd0};
    end else if (cmd.add) begin
      v_we = 1'b1;
    end else if (cmd.cmove) begin
      v_we    = 1'b1;
      v_waddr = j_r[VIW-1:0];
      v_wdata = voice_q;
    end
  end

  assign v_raddr = cmd.crd_last ? last[VIW-1:0] : i_r[VIW-1:0];
  assign c_raddr = cmd.follow ? c_next : voice_q[VDW-1 -: CW];
  assign s_sum   = {5'd0, c_start} + {4'd0, vpos_r};

  ccvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
    .clk   (clk),
    .we    (cmd.sample_wr),
    .waddr (SAW'(in_sample_addr)),
    .wdata (in_sample_value),
    .re    (cmd.srd),
    .raddr (s_sum[SAW-1:0]),
    .rdata (sample_q)
  );

  ccvm_ram #(.WIDTH(CDW), .DEPTH(CLIPS)) u_clip_ram (
    .clk   (clk),
    .we    (cmd.clip_wr),
    .waddr (WRAP_TAB[in_clip_index*CW +: CW]),
    .wdata ({in_clip_start, in_clip_length, in_has_next, WRAP_TAB[in_next_clip*CW +: CW]}),
    .re    (cmd.crd_v | cmd.follow),
    .raddr (c_raddr),
    .rdata (clip_q)
  );

  ccvm_ram #(.WIDTH(VDW), .DEPTH(VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (cmd.vrd | cmd.crd_last),
    .raddr (v_raddr),
    .rdata (voice_q)
  );

  assign add_s = 17'(acc_r) + 17'(signed'(sample_q));
  always_comb begin
    if (add_s > SAT_HI) begin
      add_sat = 16'sh7fff;
    end else if (add_s < SAT_LO) begin
      add_sat = 16'sh8000;
    end else begin
      add_sat = add_s[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        enabled_r <= cfg_wr_data;
      end
      if (cmd.voice_start && start_ok) begin
        cnt_r <= cnt_r + NW'(1);
      end
      if (cmd.cdrop || cmd.cmove) begin
        cnt_r <= last;
      end
      if (cmd.ld_start || cmd.ld_tick) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.voice_start) begin
      ok_r <= start_ok;
    end
    if (cmd.clr_mix) begin
      acc_r   <= '0;
      i_r     <= '0;
      ended_r <= '0;
    end
    if (cmd.crd_v) begin
      vclip_r    <= voice_q[VDW-1 -: CW];
      vpos_r     <= voice_q[16:0];
      reloaded_r <= 1'b0;
    end
    if (cmd.follow) begin
      vclip_r    <= c_next;
      vpos_r     <= '0;
      reloaded_r <= 1'b1;
    end
    if (cmd.end_v) begin
      ended_r[i_r[VIW-1:0]] <= 1'b1;
      i_r <= i_r + NW'(1);
    end
    if (cmd.add) begin
      acc_r <= add_sat;
      i_r   <= i_r + NW'(1);
    end
    if (cmd.cstart) begin
      j_r <= '0;
    end
    if (cmd.cmove) begin
      ended_r[j_r[VIW-1:0]] <= ended_r[last[VIW-1:0]];
    end
    if (cmd.jinc) begin
      j_r <= j_r + NW'(1);
    end
    if (cmd.ld_start) begin
      out_kind_r <= KIND_START;
      out_mix_r  <= '0;
      out_ok_r   <= ok_r;
      out_av_r   <= 5'(cnt_r);
    end
    if (cmd.ld_tick) begin
      out_kind_r <= KIND_TICK;
      out_mix_r  <= acc_r;
      out_ok_r   <= 1'b0;
      out_av_r   <= 5'(cnt_r);
    end
  end

  assign sts.i_lt_cnt   = (i_r < cnt_r);
  assign sts.pos_ge_len = (vpos_r >= c_len);
  assign sts.has_next   = c_has;
  assign sts.reloaded   = reloaded_r;
  assign sts.j_lt_cnt   = (j_r < cnt_r);
  assign sts.ended_j    = ended_r[j_r[VIW-1:0]];
  assign sts.last_eq_j  = (last == j_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_mixed_sample   = out_mix_r;
  assign out_start_accepted = out_ok_r;
  assign out_active_voices  = out_av_r;

endmodule

### design/chained_clip_voice_mixer.sv
// Sample-playback mixer with chained clips.
// Input channel (in_valid/in_stall) carries one command per transfer:
//   sample word write and clip descriptor write do not stall the input and
//   give no result; a start request gives a status result; a tick gives
//   the mixed sample.
// A tick walks the voice list one voice at a time through the voice, clip
// and sample memories (registered reads): it reads the voice entry, then its
// clip descriptor, follows the clip's link once when the clip is used up,
// then reads the sample and adds it with saturation, or marks the voice ended;
// a compaction pass then moves the last voice into each ended slot.
// Only one command is in flight; in_stall is high from acceptance until
// its result sits in the output register.
// The output register holds a result until out_stall is low; the next
// command may be accepted while it waits.
// cfg_wr_en/cfg_wr_data write the enable flag; write it only when idle.
// Reset (synchronous, rst_n low) empties the voice list, clears the enable
// flag and drops any pending result. Sample and clip memories keep no reset.
module chained_clip_voice_mixer
  import ccvm_pkg::*;
#(
  parameter int VOICES       = DEF_VOICES,
  parameter int CLIPS        = DEF_CLIPS,
  parameter int SAMPLE_WORDS = DEF_SAMPLE_WORDS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [15:0]        in_sample_addr,
  input  logic signed [15:0] in_sample_value,
  input  logic [5:0]         in_clip_index,
  input  logic [15:0]        in_clip_start,
  input  logic [16:0]        in_clip_length,
  input  logic               in_has_next,
  input  logic [5:0]         in_next_clip,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [15:0] out_mixed_sample,
  output logic               out_start_accepted,
  output logic [4:0]         out_active_voices
);

  ccvm_cmd_t cmd;
  ccvm_sts_t sts;

  ccvm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccvm_dp #(
    .VOICES       (VOICES),
    .CLIPS        (CLIPS),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_sample_addr     (in_sample_addr),
    .in_sample_value    (in_sample_value),
    .in_clip_index      (in_clip_index),
    .in_clip_start      (in_clip_start),
    .in_clip_length     (in_clip_length),
    .in_has_next        (in_has_next),
    .in_next_clip       (in_next_clip),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_mixed_sample   (out_mixed_sample),
    .out_start_accepted (out_start_accepted),
    .out_active_voices  (out_active_voices),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

### design/ccvm_checker.sv
module ccvm_checker
  import ccvm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_func,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_kind,
  input logic signed [15:0] out_mixed_sample,
  input logic               out_start_accepted
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_start_zero_mix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_START) |-> out_mixed_sample == 16'sd0)
    else $error("start result carries a mix value");

  a_tick_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TICK) |-> !out_start_accepted)
    else $error("tick result flags a start");

  a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == FN_SAMPLE || in_func == FN_CLIP) |=> !in_stall)
    else $error("memory write did not finish in one cycle");

endmodule

bind chained_clip_voice_mixer ccvm_checker u_ccvm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_func            (in_func),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_mixed_sample   (out_mixed_sample),
  .out_start_accepted (out_start_accepted)
);

### verif/tb_chained_clip_voice_mixer.sv
module tb_chained_clip_voice_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import ccvm_pkg::*;

  localparam int NV = DEF_VOICES;
  localparam int NC = DEF_CLIPS;
  localparam logic [15:0] POOL_BASE = 16'hFFC0;
  localparam int POOL_WORDS = 256;
  localparam int SETTLE = 200;

  typedef struct {
    func_t              func;
    logic [15:0]        sample_addr;
    logic signed [15:0] sample_value;
    logic [5:0]         clip_index;
    logic [15:0]        clip_start;
    logic [16:0]        clip_length;
    logic               has_next;
    logic [5:0]         next_clip;
  } cmd_t;

  typedef struct {
    kind_t              kind;
    logic signed [15:0] mixed;
    logic               accepted;
    logic [4:0]         active;
  } mix_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [15:0] in_sample_addr = '0;
  logic signed [15:0] in_sample_value = '0;
  logic [5:0] in_clip_index = '0;
  logic [15:0] in_clip_start = '0;
  logic [16:0] in_clip_length = '0;
  logic in_has_next = 1'b0;
  logic [5:0] in_next_clip = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_kind;
  logic signed [15:0] out_mixed_sample;
  logic out_start_accepted;
  logic [4:0] out_active_voices;

  chained_clip_voice_mixer DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_sample_addr(in_sample_addr), .in_sample_value(in_sample_value),
    .in_clip_index(in_clip_index), .in_clip_start(in_clip_start),
    .in_clip_length(in_clip_length), .in_has_next(in_has_next),
    .in_next_clip(in_next_clip),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_mixed_sample(out_mixed_sample), .out_start_accepted(out_start_accepted),
    .out_active_voices(out_active_voices)
  );

  always #2 clk = ~clk;

  // mixer state mirror
  logic [15:0] smem [65536];
  logic [15:0] clip_st [NC];
  logic [16:0] clip_len [NC];
  logic        clip_nx_en [NC];
  logic [5:0]  clip_nx [NC];
  logic [5:0]  vc_clip [NV];
  logic [16:0] vc_pos [NV];
  int          vc_count = 0;
  logic        mix_enabled = 1'b0;

  cmd_t cmd_q[$];
  mix_result_t mix_q[$];
  cmd_t cur;
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void mix_apply(cmd_t c);
    mix_result_t r;
    bit ended [NV];
    int acc;
    int i;
    int last;
    logic [5:0] ci;
    logic [15:0] a;
    r = '{KIND_START, 16'sd0, 1'b0, 5'd0};
    case (c.func)
      FN_SAMPLE: smem[c.sample_addr] = c.sample_value;
      FN_CLIP: begin
        clip_st[c.clip_index] = c.clip_start;
        clip_len[c.clip_index] = c.clip_length;
        clip_nx_en[c.clip_index] = c.has_next;
        clip_nx[c.clip_index] = c.next_clip;
      end
      FN_START: begin
        if (mix_enabled && vc_count < NV) begin
          vc_clip[vc_count] = c.clip_index;
          vc_pos[vc_count] = '0;
          vc_count++;
          r.accepted = 1'b1;
        end
        r.active = 5'(vc_count);
        mix_q.push_back(r);
      end
      FN_TICK: begin
        acc = 0;
        for (i = 0; i < vc_count; i++) begin
          ci = vc_clip[i];
          ended[i] = 0;
          if (vc_pos[i] >= clip_len[ci]) begin
            if (!clip_nx_en[ci]) begin
              ended[i] = 1;
              continue;
            end
            vc_clip[i] = clip_nx[ci];
            vc_pos[i] = '0;
            ci = vc_clip[i];
            if (clip_len[ci] == 0) begin
              ended[i] = 1;
              continue;
            end
          end
          a = clip_st[ci] + vc_pos[i][15:0];
          acc = acc + int'($signed(smem[a]));
          if (acc > 32767) acc = 32767;
          if (acc < -32768) acc = -32768;
          vc_pos[i] = vc_pos[i] + 17'd1;
        end
        i = 0;
        while (i < vc_count) begin
          if (ended[i]) begin
            last = vc_count - 1;
            vc_clip[i] = vc_clip[last];
            vc_pos[i] = vc_pos[last];
            ended[i] = ended[last];
            vc_count--;
          end else begin
            i++;
          end
        end
        r.kind = KIND_TICK;
        r.mixed = acc[15:0];
        r.active = 5'(vc_count);
        mix_q.push_back(r);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) mix_apply(cur);
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur = cmd_q.pop_front();
          in_func <= cur.func;
          in_sample_addr <= cur.sample_addr;
          in_sample_value <= cur.sample_value;
          in_clip_index <= cur.clip_index;
          in_clip_start <= cur.clip_start;
          in_clip_length <= cur.clip_length;
          in_has_next <= cur.has_next;
          in_next_clip <= cur.next_clip;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mix_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (mix_q.size() == 0) begin
        report("unexpected transfer", out_kind, 0);
      end else begin
        e = mix_q.pop_front();
        if (out_kind !== e.kind) report("kind", out_kind, e.kind);
        if (out_mixed_sample !== e.mixed) report("mixed_sample", out_mixed_sample, e.mixed);
        if (out_start_accepted !== e.accepted)
          report("start_accepted", out_start_accepted, e.accepted);
        if (out_active_voices !== e.active)
          report("active_voices", out_active_voices, e.active);
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic cmd_t rand_fields(func_t f);
    cmd_t c;
    c.func = f;
    c.sample_addr = 16'($urandom);
    c.sample_value = 16'($urandom);
    c.clip_index = 6'($urandom);
    c.clip_start = 16'($urandom);
    c.clip_length = 17'($urandom);
    c.has_next = 1'($urandom);
    c.next_clip = 6'($urandom);
    return c;
  endfunction

  function automatic void push_sample(logic [15:0] addr, logic [15:0] val);
    cmd_t c;
    c = rand_fields(FN_SAMPLE);
    c.sample_addr = addr;
    c.sample_value = val;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_clip(logic [5:0] idx, logic [15:0] st, logic [16:0] len,
                                    logic hn, logic [5:0] nx);
    cmd_t c;
    c = rand_fields(FN_CLIP);
    c.clip_index = idx;
    c.clip_start = st;
    c.clip_length = len;
    c.has_next = hn;
    c.next_clip = nx;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_start(logic [5:0] idx);
    cmd_t c;
    c = rand_fields(FN_START);
    c.clip_index = idx;
    cmd_q.push_back(c);
  endfunction

  function automatic void push_tick();
    cmd_q.push_back(rand_fields(FN_TICK));
  endfunction

  // clips stay inside the written window; clip 63 is never played or linked
  function automatic void push_rand_clip(logic [5:0] idx);
    int k;
    int len;
    k = $urandom_range(POOL_WORDS - 1);
    len = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, POOL_WORDS - k);
    if (len > 24 && $urandom_range(3) != 0)
      len = $urandom_range(1, 24 < POOL_WORDS - k ? 24 : POOL_WORDS - k);
    push_clip(idx, POOL_BASE + 16'(k), 17'(len), $urandom_range(9) < 3,
              6'($urandom_range(NC - 2)));
  endfunction

  function automatic void push_random(int n);
    int i;
    int w;
    for (i = 0; i < n; i++) begin
      w = $urandom_range(99);
      if (w < 40) push_tick();
      else if (w < 62) push_start(6'($urandom_range(NC - 2)));
      else if (w < 72) push_rand_clip(6'($urandom_range(NC - 2)));
      else if (w < 92)
        push_sample(POOL_BASE + 16'($urandom_range(POOL_WORDS - 1)), 16'($urandom));
      else push_sample(16'($urandom), 16'($urandom));
    end
  endfunction

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || mix_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_enable(logic v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    mix_enabled = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int idle, int stall, logic en, int n);
    set_enable(en);
    idle_pct = idle;
    stall_pct = stall;
    push_random(n);
    drain();
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the sample window and every clip descriptor
    for (i = 0; i < POOL_WORDS; i++) push_sample(POOL_BASE + 16'(i), 16'($urandom));
    push_clip(6'd63, 16'hFFFF, 17'h1FFFF, 1'b1, 6'd63);
    push_clip(6'd63, 16'h0000, 17'h10000, 1'b0, 6'd0);
    for (i = 0; i < NC - 1; i++) push_rand_clip(6'(i));
    drain();

    // disabled: starts dropped
    push_start(6'd0);
    push_start(6'd62);
    push_tick();
    drain();

    set_enable(1'b1);
    push_sample(POOL_BASE, 16'h7FFF);
    push_sample(POOL_BASE + 16'd1, 16'h8000);
    push_sample(16'h0000, 16'h7FFF);
    push_sample(16'h0001, 16'h7FFF);
    push_clip(6'd0, POOL_BASE, 17'd1, 1'b0, 6'd0);
    push_clip(6'd1, 16'hFFFF, 17'd3, 1'b1, 6'd1);
    push_clip(6'd2, POOL_BASE, 17'd0, 1'b1, 6'd0);
    push_clip(6'd3, 16'h0000, 17'd1, 1'b1, 6'd2);
    push_clip(6'd4, POOL_BASE, 17'd0, 1'b0, 6'd4);
    push_clip(6'd5, POOL_BASE + 16'd1, 17'd1, 1'b1, 6'd4);
    push_start(6'd0);
    push_start(6'd2);
    push_start(6'd3);
    push_start(6'd4);
    push_start(6'd5);
    for (i = 0; i < 12; i++) push_start(6'd1);
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    drain();

    run_phase(0, 0, 1'b1, 450);

    set_enable(1'b1);
    idle_pct = 55;
    stall_pct = 0;
    push_random(200);
    drain();
    push_random(250);
    drain();

    run_phase(0, 55, 1'b0, 250);
    run_phase(29, 29, 1'b1, 450);

    if (errors == 0) begin
      $display("tb_chained_clip_voice_mixer: PASS");
    end else begin
      $display("tb_chained_clip_voice_mixer: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_chained_clip_voice_mixer: FAIL");
    $finish;
  end

endmodule

### chained_clip_voice_mixer.f
design/ccvm_pkg.sv
design/ccvm_ram.sv
design/ccvm_ctrl.sv
design/ccvm_dp.sv
design/chained_clip_voice_mixer.sv
design/ccvm_checker.sv
verif/tb_chained_clip_voice_mixer.sv
